FILE: sv/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] MAPPER_ROM  = 2'd0;
    localparam logic [1:0] MAPPER_MBC1 = 2'd1;
    localparam logic [1:0] MAPPER_MBC3 = 2'd2;
    localparam logic [1:0] MAPPER_MBC5 = 2'd3;

    localparam logic [1:0] TARGET_NONE = 2'd0;
    localparam logic [1:0] TARGET_ROM  = 2'd1;
    localparam logic [1:0] TARGET_RAM  = 2'd2;

    localparam logic [7:0] OPEN_BUS  = 8'hFF;
    localparam int         RAM_BANK_BYTES = 8192;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  write_data;
    } access_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [22:0] rom_address;
        logic [7:0]  read_data;
    } result_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [22:0] rom_address;
        logic        ram_read;
        logic        ram_write;
        logic [3:0]  ram_bank;
    } decode_t;

endpackage

`default_nettype wire

FILE: sv/cbc_map.sv
`default_nettype none

module cbc_map #(
    parameter int RAM_BANKS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               accept,
    input  cbc_pkg::access_t  item,
    input  wire  [1:0]        mapper,
    output cbc_pkg::decode_t  dec
);
    import cbc_pkg::*;

    logic [7:0] rom_bank_reg;
    logic [7:0] rom_bank_next;
    logic       rom_bank_high_reg;
    logic       rom_bank_high_next;
    logic [3:0] ram_bank_reg;
    logic [3:0] ram_bank_next;
    logic       banking_mode_reg;
    logic       banking_mode_next;
    logic       ram_enable_reg;
    logic       ram_enable_next;

    logic [8:0] rom_sel;
    logic [3:0] ram_sel;
    logic       ram_window;
    logic       ram_ok;
    logic [1:0] region;
    logic [7:0] d;

    assign region = item.address[14:13];
    assign d      = item.write_data;

    always_comb
    begin
        rom_bank_next      = rom_bank_reg;
        rom_bank_high_next = rom_bank_high_reg;
        ram_bank_next      = ram_bank_reg;
        banking_mode_next  = banking_mode_reg;
        ram_enable_next    = ram_enable_reg;
        if (accept && item.op == OP_WRITE && !item.address[15] && mapper != MAPPER_ROM)
        begin
            if (region == 2'd0)
            begin
                ram_enable_next = ((d & 8'h0A) == 8'h0A);
            end
            else
            begin
                case (mapper)
                    MAPPER_MBC1:
                    begin
                        if (region == 2'd1)
                        begin
                            rom_bank_next = (d[4:0] == 5'd0) ? 8'd1 : {3'd0, d[4:0]};
                        end
                        else if (region == 2'd2)
                        begin
                            if (d <= 8'h03)
                            begin
                                ram_bank_next = d[3:0];
                            end
                        end
                        else
                        begin
                            banking_mode_next = d[0];
                        end
                    end
                    MAPPER_MBC3:
                    begin
                        if (region == 2'd1)
                        begin
                            rom_bank_next = (d[6:0] == 7'd0) ? 8'd1 : {1'b0, d[6:0]};
                        end
                        else if (region == 2'd2)
                        begin
                            if (d <= 8'h03)
                            begin
                                ram_bank_next = d[3:0];
                            end
                        end
                    end
                    default:
                    begin
                        if (region == 2'd1)
                        begin
                            if (!item.address[12])
                            begin
                                rom_bank_next = (d == 8'd0) ? 8'd1 : d;
                            end
                            else
                            begin
                                rom_bank_high_next = d[0];
                            end
                        end
                        else if (region == 2'd2)
                        begin
                            if (d <= 8'h0F)
                            begin
                                ram_bank_next = d[3:0];
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg      <= 8'd1;
            rom_bank_high_reg <= 1'b0;
            ram_bank_reg      <= 4'd0;
            banking_mode_reg  <= 1'b0;
            ram_enable_reg    <= 1'b0;
        end
        else
        begin
            rom_bank_reg      <= rom_bank_next;
            rom_bank_high_reg <= rom_bank_high_next;
            ram_bank_reg      <= ram_bank_next;
            banking_mode_reg  <= banking_mode_next;
            ram_enable_reg    <= ram_enable_next;
        end
    end

    always_comb
    begin
        case (mapper)
            MAPPER_MBC1:
            begin
                rom_sel = {4'd0, rom_bank_reg[4:0]};
                if (!banking_mode_reg)
                begin
                    rom_sel = rom_sel | {2'd0, ram_bank_reg[1:0], 5'd0};
                end
                ram_sel = banking_mode_reg ? {2'd0, ram_bank_reg[1:0]} : 4'd0;
            end
            MAPPER_MBC3:
            begin
                rom_sel = {2'd0, rom_bank_reg[6:0]};
                ram_sel = {2'd0, ram_bank_reg[1:0]};
            end
            MAPPER_MBC5:
            begin
                rom_sel = {rom_bank_high_reg, rom_bank_reg};
                ram_sel = ram_bank_reg;
            end
            default:
            begin
                rom_sel = 9'd0;
                ram_sel = 4'd0;
            end
        endcase
    end

    assign ram_window = (item.address[15:13] == 3'b101);
    assign ram_ok     = ram_window && mapper != MAPPER_ROM && ram_enable_reg
                        && ({1'b0, ram_sel} < 5'(RAM_BANKS));

    always_comb
    begin
        dec.target      = TARGET_NONE;
        dec.rom_address = 23'd0;
        dec.ram_read    = 1'b0;
        dec.ram_write   = 1'b0;
        dec.ram_bank    = ram_sel;
        if (!item.address[15])
        begin
            if (item.op == OP_READ)
            begin
                dec.target = TARGET_ROM;
                if (!item.address[14] || mapper == MAPPER_ROM)
                begin
                    dec.rom_address = {7'd0, item.address};
                end
                else
                begin
                    dec.rom_address = {rom_sel, item.address[13:0]};
                end
            end
        end
        else if (ram_ok)
        begin
            dec.target    = TARGET_RAM;
            dec.ram_read  = (item.op == OP_READ);
            dec.ram_write = (item.op == OP_WRITE);
        end
    end

endmodule

`default_nettype wire

FILE: sv/cartridge_bank_controller_top.sv
// Cartridge bank controller for a handheld console CPU bus.
// The bus channel (bus_valid, bus_stall, bus_item) carries one access per item:
// a read or a write with a 16-bit address and a data byte. The result channel
// (res_valid, res_stall, res_item) returns one item per access: the target
// (none, ROM fetch or external RAM), the physical ROM address and the read byte.
// The mapper kind is written through cfg_we and cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce it. Each
// result sits in an output register and appears in the cycle after its access is
// accepted. Throughput is one access per cycle while the receiver takes results;
// each RAM access uses the single-port synchronous external RAM once, when accepted.
// When the receiver stalls, the held result stays unchanged and bus_stall rises
// until it is taken.
// After reset, the bank registers take their reset values and the external RAM
// is filled with 0xFF, one byte per cycle, over all RAM_BANKS * 8192 bytes; during
// that pass bus_stall is high. Configuration writes are taken at any time.
`default_nettype none

module cartridge_bank_controller_top #(
    parameter int RAM_BANKS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_we,
    input  wire  [1:0]        cfg_wdata,
    input  wire               bus_valid,
    output logic              bus_stall,
    input  cbc_pkg::access_t  bus_item,
    output logic              res_valid,
    input  wire               res_stall,
    output cbc_pkg::result_t  res_item
);
    import cbc_pkg::*;

    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic [7:0]        mem [RAM_DEPTH];

    logic [1:0]        mapper_reg;
    logic              clr_active_reg;
    logic [RAM_AW-1:0] clr_addr_reg;
    logic              res_valid_reg;
    logic [1:0]        target_reg;
    logic [22:0]       rom_address_reg;
    logic              ram_read_reg;
    logic [7:0]        rd_reg;

    logic              accept;
    decode_t           dec;
    logic [16:0]       full_idx;
    logic [RAM_AW-1:0] idx;

    assign bus_stall = clr_active_reg || (res_valid_reg && res_stall);
    assign accept    = bus_valid && !bus_stall;
    assign full_idx  = {dec.ram_bank, bus_item.address[12:0]};
    assign idx       = full_idx[RAM_AW-1:0];

    cbc_map #(
        .RAM_BANKS(RAM_BANKS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (bus_item),
        .mapper (mapper_reg),
        .dec    (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_reg     <= MAPPER_ROM;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mapper_reg <= cfg_wdata;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg      <= dec.target;
            rom_address_reg <= dec.rom_address;
            ram_read_reg    <= dec.ram_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= OPEN_BUS;
        end
        else if (accept && dec.ram_write)
        begin
            mem[idx] <= bus_item.write_data;
        end
        if (accept && dec.ram_read)
        begin
            rd_reg <= mem[idx];
        end
    end

    assign res_valid            = res_valid_reg;
    assign res_item.target      = target_reg;
    assign res_item.rom_address = rom_address_reg;
    assign res_item.read_data   = ram_read_reg ? rd_reg : OPEN_BUS;

endmodule

`default_nettype wire

FILE: sv/cbc_check.sv
`default_nettype none

module cbc_check (
    input wire               clk,
    input wire               rst_n,
    input wire               bus_valid,
    input wire               bus_stall,
    input wire               res_valid,
    input wire               res_stall,
    input cbc_pkg::result_t  res_item
);
    import cbc_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (bus_valid && !bus_stall) |=> res_valid)
        else $error("accepted access did not produce a result item");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_item)))
        else $error("stalled result item changed");

    a_blocked_input: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |-> bus_stall)
        else $error("access accepted while a stalled result was pending");

    a_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.target != TARGET_RAM) |-> (res_item.read_data == OPEN_BUS))
        else $error("read data is not 0xFF outside a RAM access");

    a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.target != TARGET_ROM) |-> (res_item.rom_address == 23'd0))
        else $error("ROM address is nonzero outside a ROM fetch");

endmodule

bind cartridge_bank_controller_top cbc_check u_cbc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .bus_valid (bus_valid),
    .bus_stall (bus_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

`default_nettype wire

FILE: bench/tb_cartridge_bank_controller_top.sv
`timescale 1ns / 1ps

module tb_cartridge_bank_controller_top;
    import cbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAM_BYTES = 16 * RAM_BANK_BYTES;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_wdata;
    logic bus_valid;
    logic bus_stall;
    access_t bus_item;
    logic res_valid;
    logic res_stall;
    result_t res_item;

    logic [1:0] cur_mapper;
    logic [7:0] rom_bank;
    logic rom_bank_high;
    logic [3:0] ram_bank;
    logic bank_mode;
    logic ram_on;
    logic [7:0] cart_ram [0:RAM_BYTES-1];

    result_t expected_results[$];
    result_t want;
    int mismatches;
    int cycle_count;
    int sender_idle_pct;
    int stall_pct;
    int hold_seq;

    cartridge_bank_controller_top #(
        .RAM_BANKS(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .bus_valid(bus_valid),
        .bus_stall(bus_stall),
        .bus_item(bus_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cartridge_bank_controller_top regression: fail");
            $finish;
        end
    end

    function automatic void bank_reg_write(input logic [15:0] addr, input logic [7:0] d);
        if (addr <= 16'h1FFF)
        begin
            ram_on = ((d & 8'h0A) == 8'h0A);
        end
        else
        begin
            case (cur_mapper)
                MAPPER_MBC1:
                begin
                    if (addr <= 16'h3FFF)
                        rom_bank = (d[4:0] == 5'd0) ? 8'd1 : {3'd0, d[4:0]};
                    else if (addr <= 16'h5FFF)
                    begin
                        if (d <= 8'h03)
                            ram_bank = d[3:0];
                    end
                    else
                        bank_mode = d[0];
                end
                MAPPER_MBC3:
                begin
                    if (addr <= 16'h3FFF)
                        rom_bank = (d[6:0] == 7'd0) ? 8'd1 : {1'b0, d[6:0]};
                    else if (addr <= 16'h5FFF)
                    begin
                        if (d <= 8'h03)
                            ram_bank = d[3:0];
                    end
                end
                default:
                begin
                    if (addr <= 16'h2FFF)
                        rom_bank = (d == 8'd0) ? 8'd1 : d;
                    else if (addr <= 16'h3FFF)
                        rom_bank_high = d[0];
                    else if (addr <= 16'h5FFF)
                    begin
                        if (d <= 8'h0F)
                            ram_bank = d[3:0];
                    end
                end
            endcase
        end
    endfunction

    function automatic result_t bank_translate(input access_t acc);
        result_t r;
        logic [8:0] bank;
        logic [3:0] rbank;
        logic [16:0] idx;
        r.target = TARGET_NONE;
        r.rom_address = '0;
        r.read_data = OPEN_BUS;
        bank = '0;
        rbank = '0;
        if (acc.address <= 16'h7FFF)
        begin
            if (acc.op == OP_WRITE)
            begin
                if (cur_mapper != MAPPER_ROM)
                    bank_reg_write(acc.address, acc.write_data);
            end
            else
            begin
                r.target = TARGET_ROM;
                if (acc.address <= 16'h3FFF || cur_mapper == MAPPER_ROM)
                    r.rom_address = {7'd0, acc.address};
                else
                begin
                    case (cur_mapper)
                        MAPPER_MBC1:
                        begin
                            bank = {4'd0, rom_bank[4:0]};
                            if (bank_mode == 1'b0)
                                bank[6:5] = ram_bank[1:0];
                        end
                        MAPPER_MBC3:
                            bank = {2'd0, rom_bank[6:0]};
                        default:
                            bank = {rom_bank_high, rom_bank};
                    endcase
                    r.rom_address = {bank, acc.address[13:0]};
                end
            end
        end
        else if (acc.address >= 16'hA000 && acc.address <= 16'hBFFF
                 && cur_mapper != MAPPER_ROM && ram_on)
        begin
            case (cur_mapper)
                MAPPER_MBC1:
                    rbank = (bank_mode == 1'b0) ? 4'd0 : {2'd0, ram_bank[1:0]};
                MAPPER_MBC3:
                    rbank = {2'd0, ram_bank[1:0]};
                default:
                    rbank = ram_bank;
            endcase
            idx = {rbank, acc.address[12:0]};
            r.target = TARGET_RAM;
            if (acc.op == OP_WRITE)
                cart_ram[idx] = acc.write_data;
            else
                r.read_data = cart_ram[idx];
        end
        return r;
    endfunction

    function automatic access_t random_access();
        access_t a;
        int unsigned pick;
        pick = $urandom_range(99);
        a.op = 1'($urandom_range(1));
        a.address = 16'($urandom_range(16'hFFFF));
        a.write_data = 8'($urandom_range(255));
        if (pick < 12)
        begin
            a.op = OP_WRITE;
            a.address = 16'($urandom_range(16'h1FFF));
            if ($urandom_range(3) != 0)
                a.write_data = 8'h0A | 8'($urandom_range(255) & 8'hF5);
        end
        else if (pick < 27)
        begin
            a.op = OP_WRITE;
            a.address = 16'($urandom_range(16'h7FFF, 16'h2000));
            case ($urandom_range(2))
                0: a.write_data = 8'($urandom_range(3));
                1: a.write_data = 8'($urandom_range(15));
                default: a.write_data = 8'($urandom_range(255));
            endcase
        end
        else if (pick < 50)
        begin
            a.op = OP_READ;
            a.address = 16'($urandom_range(16'h7FFF));
        end
        else if (pick < 90)
        begin
            if ($urandom_range(1) != 0)
                a.address = 16'hA000 + 16'($urandom_range(31));
            else
                a.address = 16'hA000 + 16'($urandom_range(16'h1FFF));
        end
        return a;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with nothing expected: target %0d rom_address %h read_data %h",
                             res_item.target, res_item.rom_address, res_item.read_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_item.target !== want.target
                    || res_item.rom_address !== want.rom_address
                    || res_item.read_data !== want.read_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected target %0d rom_address %h read_data %h,",
                                  " got target %0d rom_address %h read_data %h"},
                                 want.target, want.rom_address, want.read_data,
                                 res_item.target, res_item.rom_address, res_item.read_data);
                end
            end
        end
    end

    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
        access_t acc;
        acc.op = op;
        acc.address = addr;
        acc.write_data = data;
        @(negedge clk);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            bus_valid <= 1'b0;
            @(negedge clk);
        end
        bus_valid <= 1'b1;
        bus_item <= acc;
        do
            @(posedge clk);
        while (bus_stall !== 1'b0);
        expected_results.push_back(bank_translate(acc));
    endtask

    task automatic send_random(input int count);
        access_t acc;
        repeat (count)
        begin
            acc = random_access();
            send_access(acc.op, acc.address, acc.write_data);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        bus_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_mapper(input logic [1:0] kind);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= kind;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_mapper = kind;
    endtask

    task automatic test_rom_only();
        set_mapper(MAPPER_ROM);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h05);
        send_access(OP_READ, 16'h7FFF, 8'hFF);
        send_access(OP_WRITE, 16'hA000, 8'h12);
        send_access(OP_READ, 16'hFFFF, 8'h00);
        wait_idle();
    endtask

    task automatic test_mbc1();
        set_mapper(MAPPER_MBC1);
        send_access(OP_WRITE, 16'h0000, 8'h0A);
        send_access(OP_WRITE, 16'h2000, 8'h00);
        send_access(OP_READ, 16'h4000, 8'h00);
        send_access(OP_WRITE, 16'h5FFF, 8'h03);
        send_access(OP_READ, 16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'h7FFF, 8'h01);
        send_access(OP_WRITE, 16'hBFFF, 8'h5A);
        send_access(OP_READ, 16'hBFFF, 8'h00);
        wait_idle();
    endtask

    task automatic test_mbc3();
        set_mapper(MAPPER_MBC3);
        send_access(OP_WRITE, 16'h3FFF, 8'h80);
        send_access(OP_READ, 16'h4000, 8'h00);
        send_access(OP_WRITE, 16'h4000, 8'h04);
        send_access(OP_WRITE, 16'h6000, 8'hFF);
        send_access(OP_WRITE, 16'h1FFF, 8'h00);
        send_access(OP_READ, 16'hA000, 8'h00);
        wait_idle();
    endtask

    task automatic test_mbc5();
        set_mapper(MAPPER_MBC5);
        send_access(OP_WRITE, 16'h2FFF, 8'hFF);
        send_access(OP_WRITE, 16'h3000, 8'h01);
        send_access(OP_READ, 16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'h0000, 8'h0A);
        send_access(OP_WRITE, 16'h4000, 8'h0F);
        send_access(OP_READ, 16'hA000, 8'h00);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 12; phase++)
        begin
            set_mapper(2'((phase + phase / 4) % 4));
            case (phase % 4)
                0: begin sender_idle_pct = 0; stall_pct = 0; end
                1: begin sender_idle_pct = 60; stall_pct = 0; end
                2: begin sender_idle_pct = 0; stall_pct = 60; end
                default: begin sender_idle_pct = 19; stall_pct = 19; end
            endcase
            send_random(100);
            wait_idle();
        end
        sender_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_mapper(MAPPER_MBC1);
        sender_idle_pct = 0;
        stall_pct = 19;
        hold_seq++;
        send_random(60);
        wait_idle();
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = MAPPER_ROM;
        bus_valid = 1'b0;
        bus_item = '0;
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_seq = 0;
        cur_mapper = MAPPER_ROM;
        rom_bank = 8'd1;
        rom_bank_high = 1'b0;
        ram_bank = 4'd0;
        bank_mode = 1'b0;
        ram_on = 1'b0;
        for (int i = 0; i < RAM_BYTES; i++)
            cart_ram[i] = OPEN_BUS;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_rom_only();
        test_mbc1();
        test_mbc3();
        test_mbc5();
        test_random_traffic();
        test_backpressure();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("cartridge_bank_controller_top regression: pass");
        else
            $display("cartridge_bank_controller_top regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/cbc_pkg.sv
sv/cbc_map.sv
sv/cartridge_bank_controller_top.sv
sv/cbc_check.sv
bench/tb_cartridge_bank_controller_top.sv
